// ===== rtl/rws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rws_pkg: shared types and constants
// Field widths, opcodes and adder/subtracter op codes of the roulette selector.
// ---------------------------------------------------------------------------
package rws_pkg;

    localparam int OPC_W      = 1;
    localparam int IDX_W      = 6;
    localparam int FIT_IN_W   = 16;
    localparam int RND_W      = 31;
    localparam int POP_SIZE_W = 7;
    localparam int BIT_W      = $clog2(RND_W);

    localparam logic [POP_SIZE_W-1:0] POP_SIZE_RESET = 7'd64;

    typedef logic [OPC_W-1:0] opcode_t;
    localparam opcode_t OPC_LOAD   = 1'b0;
    localparam opcode_t OPC_SELECT = 1'b1;

    typedef logic alu_op_t;
    localparam alu_op_t ALU_ADD = 1'b0;
    localparam alu_op_t ALU_SUB = 1'b1;

endpackage : rws_pkg
`default_nettype wire

// ===== rtl/rws_addsub.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rws_addsub: shared adder/subtracter
// One carry chain for the fitness sum, the modulo steps and the scan.
// ---------------------------------------------------------------------------
module rws_addsub #(
    parameter int WIDTH = 23
) (
    input  rws_pkg::alu_op_t   op,
    input  logic [WIDTH-1:0]   a,
    input  logic [WIDTH-1:0]   b,
    output logic [WIDTH-1:0]   result,
    output logic               carry
);
    import rws_pkg::*;

    logic [WIDTH-1:0] b_eff;

    // carry is the no-borrow flag when subtracting
    assign b_eff = (op == ALU_SUB) ? ~b : b;
    assign {carry, result} = {1'b0, a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, (op == ALU_SUB)};

endmodule : rws_addsub
`default_nettype wire

// ===== rtl/rws_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rws_store: fitness memory
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module rws_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule : rws_store
`default_nettype wire

// ===== rtl/roulette_wheel_selector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// roulette_wheel_selector: fitness-proportionate parent selection
// Fitness store, sum / modulo / scan sequencer over one shared adder.
// ---------------------------------------------------------------------------
// Input channel (in_valid / in_stall): opcode load writes fitness_value into
//   entry entry_index (ignored when not below POP_MAX), no result;
//   opcode select starts one selection using random_word.
// Output channel (out_valid / out_stall): one word per select, chosen_index
//   and zero_total_error. A finished word waits in the output register; loads
//   are still taken meanwhile, but the next select cannot hand over its result
//   until that word is taken. in_stall stays high while a select runs.
// Config channel (cfg_valid / cfg_ready): population_size, always ready;
//   write it only while idle. Values above POP_MAX act as POP_MAX.
// Sequence: a select, n entries taking part, sums them through the registered
//   read port, runs 31 restoring modulo steps, scans down from the top entry
//   and hands off; a zero total skips the modulo steps and the scan. A new
//   select is taken only after the last one has handed off. All arithmetic shares one adder.
// Reset: control clears at once, population_size returns to 64, then a
//   clearing pass over all POP_MAX entries zeroes the store with in_stall high.
// ---------------------------------------------------------------------------
module roulette_wheel_selector #(
    parameter int POP_MAX  = 64,
    parameter int FIT_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // item input
    input  logic                               in_valid,
    output logic                               in_stall,
    input  rws_pkg::opcode_t                   opcode,
    input  logic [rws_pkg::IDX_W-1:0]          entry_index,
    input  logic [rws_pkg::FIT_IN_W-1:0]       fitness_value,
    input  logic [rws_pkg::RND_W-1:0]          random_word,
    // result output
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rws_pkg::IDX_W-1:0]          chosen_index,
    output logic                               zero_total_error,
    // configuration
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rws_pkg::POP_SIZE_W-1:0]     cfg_data
);
    import rws_pkg::*;

    localparam int AW    = $clog2(POP_MAX);
    localparam int CNT_W = $clog2(POP_MAX + 1);
    localparam int SUM_W = FIT_BITS + AW;
    localparam int ALU_W = SUM_W + 1;
    localparam int CMP_W = (CNT_W > POP_SIZE_W) ? CNT_W : POP_SIZE_W;

    // sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_MOD   = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic [POP_SIZE_W-1:0] pop_reg;
    logic                  out_valid_reg, out_valid_next;

    // datapath registers
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pidx_reg, pidx_next;
    logic [SUM_W-1:0]      acc_reg, acc_next;      // total fitness
    logic [SUM_W-1:0]      rem_reg, rem_next;      // remainder, then scan residue
    logic [RND_W-1:0]      rnd_reg, rnd_next;
    logic [BIT_W-1:0]      bit_reg, bit_next;
    logic [AW-1:0]         pick_reg, pick_next;
    logic                  err_reg, err_next;
    logic [IDX_W-1:0]      out_idx_reg;
    logic                  out_err_reg;

    // store ports
    logic                  st_we;
    logic [AW-1:0]         st_waddr;
    logic [FIT_BITS-1:0]   st_wdata;
    logic [AW-1:0]         st_raddr;
    logic [FIT_BITS-1:0]   st_rdata;

    // shared adder
    alu_op_t               alu_op;
    logic [ALU_W-1:0]      alu_a, alu_b, alu_res;
    logic                  alu_carry;

    logic                  in_accept;
    logic                  load_ok;
    logic                  out_load;
    logic [CMP_W-1:0]      pop_w;
    logic [CNT_W-1:0]      n_eff;
    logic [CNT_W-1:0]      cnt_m1;
    logic [ALU_W-1:0]      shifted;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // population size, saturated to the store depth
    assign pop_w = CMP_W'(pop_reg);
    assign n_eff = (pop_w > CMP_W'(POP_MAX)) ? CNT_W'(POP_MAX) : CNT_W'(pop_w);

    assign load_ok = CMP_W'(entry_index) < CMP_W'(POP_MAX);
    assign cnt_m1  = cnt_reg - CNT_W'(1);
    assign shifted = {rem_reg, rnd_reg[RND_W-1]};

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    rws_store #(
        .DEPTH (POP_MAX),
        .WIDTH (FIT_BITS)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    rws_addsub #(
        .WIDTH (ALU_W)
    ) u_addsub (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_res),
        .carry  (alu_carry)
    );

    // store write: clearing pass or load word
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            st_we    = 1'b1;
            st_waddr = clr_reg;
            st_wdata = '0;
        end
        else
        begin
            st_we    = in_accept && (opcode == OPC_LOAD) && load_ok;
            st_waddr = AW'(entry_index);
            st_wdata = FIT_BITS'(fitness_value);
        end
    end

    // read address: ascending while summing, descending while scanning
    assign st_raddr = (state_reg == ST_SCAN) ? cnt_m1[AW-1:0] : cnt_reg[AW-1:0];

    // adder operand select
    always_comb
    begin
        unique case (state_reg)
            ST_SUM:
            begin
                alu_op = ALU_ADD;
                alu_a  = ALU_W'(acc_reg);
                alu_b  = ALU_W'(st_rdata);
            end
            ST_MOD:
            begin
                alu_op = ALU_SUB;
                alu_a  = shifted;
                alu_b  = ALU_W'(acc_reg);
            end
            default:
            begin
                alu_op = ALU_SUB;
                alu_a  = ALU_W'(rem_reg);
                alu_b  = ALU_W'(st_rdata);
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        pidx_next  = pidx_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        rnd_next   = rnd_reg;
        bit_next   = bit_reg;
        pick_next  = pick_reg;
        err_next   = err_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(POP_MAX - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept && (opcode == OPC_SELECT))
                begin
                    n_next     = n_eff;
                    cnt_next   = '0;
                    pend_next  = 1'b0;
                    acc_next   = '0;
                    rnd_next   = random_word;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                // read issued this cycle lands next cycle
                if (cnt_reg != n_reg)
                begin
                    cnt_next  = cnt_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    acc_next = alu_res[SUM_W-1:0];
                end
                if ((cnt_reg == n_reg) && !pend_reg)
                begin
                    if (acc_reg == '0)
                    begin
                        err_next   = 1'b1;
                        pick_next  = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        err_next   = 1'b0;
                        rem_next   = '0;
                        bit_next   = '0;
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                // restoring step: one random bit per cycle
                rem_next = alu_carry ? alu_res[SUM_W-1:0] : shifted[SUM_W-1:0];
                rnd_next = {rnd_reg[RND_W-2:0], 1'b0};
                bit_next = bit_reg + BIT_W'(1);
                if (bit_reg == BIT_W'(RND_W - 1))
                begin
                    cnt_next   = n_reg;
                    pend_next  = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg != '0)
                begin
                    cnt_next  = cnt_m1;
                    pidx_next = cnt_m1[AW-1:0];
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    // borrow: running sum has passed the threshold
                    if (!alu_carry)
                    begin
                        pick_next  = pidx_reg;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rem_next = alu_res[SUM_W-1:0];
                    end
                end
                else if (cnt_reg == '0)
                begin
                    pick_next  = AW'(n_reg - CNT_W'(1));
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pop_reg       <= POP_SIZE_RESET;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            if (cfg_valid && cfg_ready)
            begin
                pop_reg <= cfg_data;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        cnt_reg  <= cnt_next;
        pidx_reg <= pidx_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        rnd_reg  <= rnd_next;
        bit_reg  <= bit_next;
        pick_reg <= pick_next;
        err_reg  <= err_next;
        if (out_load)
        begin
            out_idx_reg <= IDX_W'(pick_reg);
            out_err_reg <= err_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign chosen_index     = out_idx_reg;
    assign zero_total_error = out_err_reg;

endmodule : roulette_wheel_selector
`default_nettype wire
